// ===== sv/tpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared constants for the tiled palette frame decoder.
// ----------------------------------------------------------------------------
package tpfd_pkg;

  // Closing status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CORRUPT  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Tile geometry: 8x8 pixels, 64 per tile
  localparam int TILE_SHIFT = 3;
  localparam int TILE_PIX_SHIFT = 6;

  // Tile index divider widths
  localparam int DIV_N_W = 16;
  localparam int DIV_D_W = 9;

  typedef logic [DIV_N_W-1:0] div_num_t;
  typedef logic [DIV_D_W-1:0] div_den_t;

endpackage

// ===== sv/tiled_palette_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tiled_palette_frame_decoder_top
// Byte-serial frame payload decoder: tile list, palette and pixel parsing,
// at most one framebuffer write per decoded pixel.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transaction
// s_axis    in         tdata = data_byte, tlast = last_byte
// m_axis    out        tdata = pixel_address, color, status; tuser = pixel_valid;
//                      tlast = frame_done
// apb       in/out     registers frame_width 0x0, frame_height 0x4,
//                      indexed_mode 0x8, tiled_mode 0xC
//
// Sequence: each byte is taken in IDLE and decoded in DECODE; a result goes
// through EMIT to the output register. A tiled pixel walks TILE, ADDR and
// FIN, with DIV before ADDR when its tile index differs from the cached one
// (the restoring divider that splits the index into row and column).
// Reset: synchronous, clears the parser; the tile and palette memories keep
// their contents and are only read where the stream has written them.
// Stalls: m_axis holds a result while tready is low; one more result may be
// ready behind it before s_axis stops taking bytes.
//
module tiled_palette_frame_decoder_top
  import tpfd_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_TILES     = 16384,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  // framebuffer write stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [19:0] pixel_address, [35:20] color,
                                      // [37:36] status, [39:38] zero
  output logic        m_axis_tuser,   // [0] pixel_valid
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TA_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int TX_W = (TA_W > 16) ? TA_W : 16;
  localparam int PA_W = $clog2(PALETTE_DEPTH);

  // parse phases
  localparam logic [2:0] PH_BEGIN   = 3'd0;
  localparam logic [2:0] PH_TCNT_HI = 3'd1;
  localparam logic [2:0] PH_TLIST   = 3'd2;
  localparam logic [2:0] PH_PCNT_LO = 3'd3;
  localparam logic [2:0] PH_PCNT_HI = 3'd4;
  localparam logic [2:0] PH_PAL     = 3'd5;
  localparam logic [2:0] PH_PIX     = 3'd6;
  localparam logic [2:0] PH_DRAIN   = 3'd7;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_TILE   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_ADDR   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_INDEXED = 2'd2;
  localparam logic [1:0] REG_TILED   = 2'd3;

  // configuration registers
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic        indexed_mode;
  logic        tiled_mode;

  // parser state
  logic [2:0]  state;
  logic [2:0]  phase;
  logic [17:0] sc;
  logic [7:0]  hold;
  logic [15:0] tile_total;
  logic [15:0] palette_size;
  logic [21:0] pixel_counter;
  logic [7:0]  byte_q;
  logic        last_q;

  // tiled pixel working registers
  logic [15:0] idx_q;
  logic [15:0] color_q;
  logic [19:0] addr_q;
  logic        vld_q;
  logic [7:0]  tcol;
  logic [7:0]  trow;
  logic        cache_ok;
  logic [15:0] cache_idx;
  logic [8:0]  cache_tpr;

  // pending result
  logic        res_valid;
  logic [19:0] res_addr;
  logic [15:0] res_color;
  logic        res_done;
  logic [1:0]  res_status;

  // memories
  logic        tile_we;
  logic [15:0] tile_rd;
  logic        pal_we;
  logic [15:0] pal_rd;
  logic [TX_W-1:0] tile_t;
  logic [16:0] entry;

  // derived geometry
  logic [10:0] w_eff;
  logic [10:0] h_eff;
  logic [8:0]  tpr;
  logic [8:0]  tpc;
  logic [16:0] tiles_in_frame;
  logic [15:0] tt_new;
  logic [15:0] tt_eff;
  logic [21:0] total;
  logic [21:0] cur_pc;
  logic [17:0] cur_sc;
  logic [21:0] pc_inc;
  logic [17:0] sc_inc;
  logic        cache_hit;
  logic        tile_bad;
  logic [10:0] px;
  logic [10:0] py;

  // divider
  logic        div_start;
  logic        div_done;
  div_num_t    div_q;
  div_den_t    div_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd256;
      frame_height <= 11'd192;
      indexed_mode <= 1'b0;
      tiled_mode   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_WIDTH:   frame_width  <= pwdata[10:0];
        REG_HEIGHT:  frame_height <= pwdata[10:0];
        REG_INDEXED: indexed_mode <= pwdata[0];
        REG_TILED:   tiled_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:   prdata = {21'd0, frame_width};
      REG_HEIGHT:  prdata = {21'd0, frame_height};
      REG_INDEXED: prdata = {31'd0, indexed_mode};
      REG_TILED:   prdata = {31'd0, tiled_mode};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Geometry and counts
  // --------------------------------------------------------------------------
  assign w_eff = (32'(frame_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : frame_width;
  assign h_eff = (32'(frame_height) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : frame_height;
  assign tpr   = 9'((12'(w_eff) + 12'd7) >> TILE_SHIFT);
  assign tpc   = 9'((12'(h_eff) + 12'd7) >> TILE_SHIFT);
  assign tiles_in_frame = 17'(18'(tpr) * 18'(tpc));

  // tile count being completed this byte counts already
  assign tt_new = {byte_q, hold};
  assign tt_eff = (state == ST_DECODE && phase == PH_TCNT_HI) ? tt_new : tile_total;
  assign total  = tiled_mode ? {tt_eff, 6'd0} : (22'(w_eff) * 22'(h_eff));

  assign cur_pc = (phase == PH_BEGIN) ? 22'd0 : pixel_counter;
  assign cur_sc = (phase == PH_BEGIN) ? 18'd0 : sc;
  assign pc_inc = cur_pc + 22'd1;
  assign sc_inc = sc + 18'd1;

  assign cache_hit = cache_ok && (cache_idx == idx_q) && (cache_tpr == tpr);
  assign tile_bad  = (17'(idx_q) >= tiles_in_frame);
  assign div_start = (state == ST_TILE) && !tile_bad && !cache_hit;

  assign px = 11'({tcol, 3'd0}) + 11'(pixel_counter[2:0]);
  assign py = 11'({trow, 3'd0}) + 11'(pixel_counter[5:3]);

  // --------------------------------------------------------------------------
  // Tile list and palette memories
  // --------------------------------------------------------------------------
  assign entry   = sc[17:1];
  assign tile_t  = TX_W'(pixel_counter[21:TILE_PIX_SHIFT]);
  assign tile_we = (state == ST_DECODE) && (phase == PH_TLIST) && sc[0] &&
                   (32'(entry) < MAX_TILES);
  assign pal_we  = (state == ST_DECODE) && (phase == PH_PAL) && sc[0] &&
                   (32'(entry) < PALETTE_DEPTH);

  tpfd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_TILES)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (TA_W'(entry)),
    .wdata ({byte_q, hold}),
    .raddr (tile_t[TA_W-1:0]),
    .rdata (tile_rd)
  );

  // read at the palette index while the byte is taken
  tpfd_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (entry[PA_W-1:0]),
    .wdata ({byte_q, hold}),
    .raddr (s_axis_tdata[PA_W-1:0]),
    .rdata (pal_rd)
  );

  tpfd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (idx_q),
    .divisor   (tpr),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // --------------------------------------------------------------------------
  // Byte sequencer
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin : seq
    logic        cl;
    logic        cl_v;
    logic [1:0]  cl_st;
    logic        em;
    logic        fin;
    logic        fv;
    logic        pix;
    logic        ent;
    logic        lchk;
    logic        nf;
    logic [19:0] ra;
    logic [15:0] rc;
    logic [2:0]  nxt;
    logic [15:0] ps_new;

    cl    = 1'b0;
    cl_v  = 1'b0;
    cl_st = STATUS_OK;
    em    = 1'b0;
    fin   = 1'b0;
    fv    = 1'b0;
    pix   = 1'b0;
    ent   = 1'b0;
    lchk  = 1'b0;
    nf    = 1'b0;
    ra    = '0;
    rc    = '0;
    nxt   = state;
    ps_new = {byte_q, hold};

    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_BEGIN;
      sc            <= '0;
      hold          <= '0;
      tile_total    <= '0;
      palette_size  <= '0;
      pixel_counter <= '0;
      cache_ok      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            byte_q <= s_axis_tdata;
            last_q <= s_axis_tlast;
            nxt    = ST_DECODE;
          end
        end

        ST_DECODE: begin
          nxt = ST_IDLE;
          case (phase)
            PH_BEGIN: begin
              if (tiled_mode) begin
                hold  <= byte_q;
                phase <= PH_TCNT_HI;
                lchk  = 1'b1;
              end else if (indexed_mode) begin
                hold  <= byte_q;
                phase <= PH_PCNT_HI;
                lchk  = 1'b1;
              end else begin
                phase         <= PH_PIX;
                sc            <= '0;
                pixel_counter <= '0;
                pix           = 1'b1;
              end
            end
            PH_TCNT_HI: begin
              tile_total <= tt_new;
              if (32'(tt_new) > MAX_TILES) begin
                cl    = 1'b1;
                cl_st = STATUS_OVERFLOW;
              end else begin
                sc <= '0;
                if (tt_new == 16'd0) begin
                  if (!indexed_mode) begin
                    ent = 1'b1;
                  end else begin
                    phase <= PH_PCNT_LO;
                    lchk  = 1'b1;
                  end
                end else begin
                  phase <= PH_TLIST;
                  lchk  = 1'b1;
                end
              end
            end
            PH_TLIST: begin
              if (!sc[0]) begin
                hold <= byte_q;
              end
              sc <= sc_inc;
              if (sc_inc >= 18'({tile_total, 1'b0})) begin
                sc <= '0;
                if (!indexed_mode) begin
                  ent = 1'b1;
                end else begin
                  phase <= PH_PCNT_LO;
                  lchk  = 1'b1;
                end
              end else begin
                lchk = 1'b1;
              end
            end
            PH_PCNT_LO: begin
              hold  <= byte_q;
              phase <= PH_PCNT_HI;
              lchk  = 1'b1;
            end
            PH_PCNT_HI: begin
              palette_size <= ps_new;
              if (ps_new == 16'd0) begin
                cl    = 1'b1;
                cl_st = STATUS_CORRUPT;
              end else begin
                sc    <= '0;
                phase <= PH_PAL;
                lchk  = 1'b1;
              end
            end
            PH_PAL: begin
              if (!sc[0]) begin
                hold <= byte_q;
              end
              sc <= sc_inc;
              if (sc_inc >= 18'({palette_size, 1'b0})) begin
                ent = 1'b1;
              end else begin
                lchk = 1'b1;
              end
            end
            PH_PIX: pix = 1'b1;
            default: begin
              // drain to the end of the payload
              if (last_q) begin
                nf = 1'b1;
              end
            end
          endcase

          if (pix) begin
            if (cur_pc >= total) begin
              cl    = 1'b1;
              cl_st = STATUS_OK;
            end else if (indexed_mode) begin
              if (16'(byte_q) >= palette_size) begin
                cl    = 1'b1;
                cl_st = STATUS_CORRUPT;
              end else begin
                rc  = pal_rd;
                fin = 1'b1;
              end
            end else if (!cur_sc[0]) begin
              hold <= byte_q;
              sc   <= 18'd1;
              lchk = 1'b1;
            end else begin
              sc  <= '0;
              rc  = {byte_q, hold};
              fin = 1'b1;
            end
            // tiled pixels leave here for the address walk
            if (fin && tiled_mode) begin
              fin     = 1'b0;
              color_q <= rc;
              idx_q   <= (32'(tile_t) < MAX_TILES) ? tile_rd : 16'd0;
              nxt     = ST_TILE;
            end else begin
              fv = 1'b1;
              ra = cur_pc[19:0];
            end
          end

          if (ent) begin
            phase         <= PH_PIX;
            sc            <= '0;
            pixel_counter <= '0;
            if (total == 22'd0) begin
              cl    = 1'b1;
              cl_st = STATUS_OK;
            end else begin
              lchk = 1'b1;
            end
          end

          if (lchk && last_q) begin
            cl    = 1'b1;
            cl_st = STATUS_CORRUPT;
          end
        end

        ST_TILE: begin
          if (tile_bad) begin
            cl    = 1'b1;
            cl_st = STATUS_CORRUPT;
          end else if (cache_hit) begin
            nxt = ST_ADDR;
          end else begin
            nxt = ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            cache_ok  <= 1'b1;
            cache_idx <= idx_q;
            cache_tpr <= tpr;
            tcol      <= div_r[7:0];
            trow      <= div_q[7:0];
            nxt       = ST_ADDR;
          end
        end

        ST_ADDR: begin
          vld_q  <= (px < w_eff) && (py < h_eff);
          addr_q <= 20'(22'(py) * 22'(w_eff) + 22'(px));
          nxt    = ST_FIN;
        end

        ST_FIN: begin
          fin = 1'b1;
          fv  = vld_q;
          ra  = addr_q;
          rc  = color_q;
        end

        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            nxt = ST_IDLE;
          end
        end

        default: nxt = ST_IDLE;
      endcase

      // pixel completed: count it, then close, or emit it when it lies in the frame
      if (fin) begin
        pixel_counter <= pc_inc;
        nxt           = ST_IDLE;
        if (pc_inc >= total) begin
          cl    = 1'b1;
          cl_v  = fv;
          cl_st = STATUS_OK;
        end else if (last_q) begin
          cl    = 1'b1;
          cl_st = STATUS_CORRUPT;
        end else if (fv) begin
          em = 1'b1;
        end
      end

      if (cl) begin
        res_valid  <= cl_v;
        res_addr   <= cl_v ? ra : 20'd0;
        res_color  <= cl_v ? rc : 16'd0;
        res_done   <= 1'b1;
        res_status <= cl_st;
        nxt        = ST_EMIT;
        if (last_q) begin
          nf = 1'b1;
        end else begin
          phase <= PH_DRAIN;
        end
      end else if (em) begin
        res_valid  <= 1'b1;
        res_addr   <= ra;
        res_color  <= rc;
        res_done   <= 1'b0;
        res_status <= STATUS_OK;
        nxt        = ST_EMIT;
      end

      // start a fresh frame
      if (nf) begin
        phase         <= PH_BEGIN;
        sc            <= '0;
        hold          <= '0;
        tile_total    <= '0;
        palette_size  <= '0;
        pixel_counter <= '0;
      end

      state <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {2'b00, res_status, res_color, res_addr};
      m_axis_tuser  <= res_valid;
      m_axis_tlast  <= res_done;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

// ===== sv/tpfd_ram.sv =====
// ----------------------------------------------------------------------------
// tpfd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tpfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tpfd_div.sv =====
// ----------------------------------------------------------------------------
// tpfd_div
// Restoring divider, one quotient bit per cycle: splits a tile index into
// tile row (quotient) and tile column (remainder).
// ----------------------------------------------------------------------------
module tpfd_div
  import tpfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  div_num_t dividend,
  input  div_den_t divisor,
  output logic     done,
  output div_num_t quotient,
  output div_den_t remainder
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [CNT_W-1:0] count;
  logic             busy;
  div_den_t         den;
  logic [DIV_D_W:0] trial;
  logic [DIV_D_W:0] diff;

  // shift in the next dividend bit, subtract when it fits
  assign trial = {remainder, quotient[DIV_N_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= CNT_W'(DIV_N_W);
        quotient  <= dividend;
        remainder <= '0;
        den       <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          remainder <= diff[DIV_D_W-1:0];
          quotient  <= {quotient[DIV_N_W-2:0], 1'b1};
        end else begin
          remainder <= trial[DIV_D_W-1:0];
          quotient  <= {quotient[DIV_N_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/tiled_palette_frame_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// tiled_palette_frame_decoder_top_test
// Drives frame payloads (raw, indexed, tiled, broken and noisy) into the
// decoder, predicts every framebuffer write and closing transaction, and
// checks the output stream field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tiled_palette_frame_decoder_top_test;
  import tpfd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int TARGET_ITEMS = 1250;
  localparam int SETTLE       = 60;     // worst tiled pixel plus output slack
  localparam int N_TILES      = 16384;
  localparam int N_PAL        = 256;

  // register indexes, byte address is 4 * index
  localparam int REG_WIDTH  = 0;
  localparam int REG_HEIGHT = 1;
  localparam int REG_INDEX  = 2;
  localparam int REG_TILED  = 3;

  typedef enum logic [2:0] {
    P_BEGIN, P_TCNT_HI, P_TLIST, P_PCNT_LO, P_PCNT_HI, P_PAL, P_PIX, P_DRAIN
  } parse_phase_e;

  typedef enum int {FK_GOOD, FK_EARLY, FK_TRAIL, FK_CORRUPT, FK_NOISE} frame_kind_e;

  typedef struct {
    bit        pv;
    bit [19:0] addr;
    bit [15:0] color;
    bit        done;
    bit [1:0]  status;
  } fb_write_t;

  typedef struct {
    bit [7:0] b;
    bit       l;
  } payload_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tiled_palette_frame_decoder_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame decode predictor: own copy of registers, parser state and stores
  // --------------------------------------------------------------------------
  int unsigned  cfg_w = 256, cfg_h = 192;
  bit           cfg_idx = 1'b0, cfg_tiled = 1'b0;
  parse_phase_e ph = P_BEGIN;
  int unsigned  sec_cnt, low_hold, tile_num, pal_count, pix_cnt;
  bit [15:0]    tile_map [N_TILES];
  bit [15:0]    palette_mem [N_PAL];

  fb_write_t    pending_writes [$];   // predicted output transactions, oldest first
  payload_byte_t frame_q [$];

  int unsigned cycles = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          writes_seen = 0;
  int          frames_sent = 0;
  int          closes_seen = 0;
  bit          idle_en = 1'b1;
  int          long_hold = 0;
  int          stall_left = 0;

  function automatic int unsigned eff_w();
    return (cfg_w > 1024) ? 1024 : cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h > 1024) ? 1024 : cfg_h;
  endfunction

  function automatic void frame_restart();
    ph = P_BEGIN;
    sec_cnt = 0;
    low_hold = 0;
    tile_num = 0;
    pal_count = 0;
    pix_cnt = 0;
  endfunction

  function automatic int unsigned pix_total();
    return cfg_tiled ? tile_num * 64 : eff_w() * eff_h();
  endfunction

  function automatic bit close_frame(bit v, int unsigned a, int unsigned c, bit [1:0] st,
                                     bit last, output fb_write_t r);
    r.pv = v;
    r.addr = v ? a[19:0] : '0;
    r.color = v ? c[15:0] : '0;
    r.done = 1'b1;
    r.status = st;
    if (last) frame_restart();
    else ph = P_DRAIN;
    return 1'b1;
  endfunction

  function automatic bit start_pixels(bit last, output fb_write_t r);
    ph = P_PIX;
    sec_cnt = 0;
    pix_cnt = 0;
    if (pix_total() == 0) return close_frame(0, 0, 0, STATUS_OK, last, r);
    if (last) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
    return 1'b0;
  endfunction

  function automatic bit decode_pixel(int unsigned b, bit last, output fb_write_t r);
    int unsigned total, c, a, w, h, t, k, tpr, tpc, idx, col, row, px, py;
    bit v;
    total = pix_total();
    v = 1'b1;
    if (pix_cnt >= total) return close_frame(0, 0, 0, STATUS_OK, last, r);
    if (cfg_idx) begin
      if (b >= pal_count) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
      c = palette_mem[b[7:0]];
    end else begin
      if ((sec_cnt & 1) == 0) begin
        low_hold = b;
        sec_cnt = 1;
        if (last) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
        return 1'b0;
      end
      sec_cnt = 0;
      c = low_hold | (b << 8);
    end
    a = pix_cnt;
    if (cfg_tiled) begin
      w = eff_w();
      h = eff_h();
      t = pix_cnt >> 6;
      k = pix_cnt & 63;
      tpr = (w + 7) >> 3;
      tpc = (h + 7) >> 3;
      idx = (t < N_TILES) ? tile_map[t] : 0;
      if (idx >= tpr * tpc) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
      col = idx % tpr;
      row = idx / tpr;
      px = col * 8 + (k & 7);
      py = row * 8 + (k >> 3);
      if (px < w && py < h) a = py * w + px;
      else v = 1'b0;
    end
    pix_cnt++;
    if (pix_cnt >= total) return close_frame(v, a, c, STATUS_OK, last, r);
    if (last) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
    if (!v) return 1'b0;
    r.pv = 1'b1;
    r.addr = a[19:0];
    r.color = c[15:0];
    r.done = 1'b0;
    r.status = STATUS_OK;
    return 1'b1;
  endfunction

  // Advance the predictor by one payload byte; returns 1 when a write is due.
  function automatic bit decode_byte(int unsigned b, bit last, output fb_write_t r);
    int unsigned e;
    r = '{default: 0};
    case (ph)
      P_BEGIN: begin
        if (cfg_tiled) begin
          low_hold = b;
          ph = P_TCNT_HI;
        end else if (cfg_idx) begin
          low_hold = b;
          ph = P_PCNT_HI;
        end else begin
          ph = P_PIX;
          sec_cnt = 0;
          pix_cnt = 0;
          return decode_pixel(b, last, r);
        end
      end
      P_TCNT_HI: begin
        tile_num = low_hold | (b << 8);
        if (tile_num > N_TILES) return close_frame(0, 0, 0, STATUS_OVERFLOW, last, r);
        sec_cnt = 0;
        if (tile_num == 0) begin
          if (!cfg_idx) return start_pixels(last, r);
          ph = P_PCNT_LO;
        end else begin
          ph = P_TLIST;
        end
      end
      P_TLIST: begin
        if ((sec_cnt & 1) == 0) begin
          low_hold = b;
        end else begin
          e = sec_cnt >> 1;
          if (e < N_TILES) tile_map[e] = low_hold | (b << 8);
        end
        sec_cnt++;
        if (sec_cnt >= tile_num * 2) begin
          sec_cnt = 0;
          if (!cfg_idx) return start_pixels(last, r);
          ph = P_PCNT_LO;
        end
      end
      P_PCNT_LO: begin
        low_hold = b;
        ph = P_PCNT_HI;
      end
      P_PCNT_HI: begin
        pal_count = low_hold | (b << 8);
        if (pal_count == 0) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
        sec_cnt = 0;
        ph = P_PAL;
      end
      P_PAL: begin
        if ((sec_cnt & 1) == 0) begin
          low_hold = b;
        end else begin
          e = sec_cnt >> 1;
          if (e < N_PAL) palette_mem[e] = low_hold | (b << 8);
        end
        sec_cnt++;
        if (sec_cnt >= pal_count * 2) return start_pixels(last, r);
      end
      P_PIX: return decode_pixel(b, last, r);
      default: begin
        if (last) frame_restart();
        return 1'b0;
      end
    endcase
    if (last) return close_frame(0, 0, 0, STATUS_CORRUPT, last, r);
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d writes still pending",
               cycles, pending_writes.size());
      $display("tiled_palette_frame_decoder_top_test NOT OK");
      $finish;
    end
  end

  function automatic void note_mismatch(string what);
    if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endfunction

  // --------------------------------------------------------------------------
  // Output checker: compare each accepted transaction with the oldest
  // predicted write
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_writes
    fb_write_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      writes_seen++;
      if (m_axis_tlast) closes_seen++;
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction tdata=%h tuser=%b tlast=%b",
                                m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        e = pending_writes.pop_front();
        if (m_axis_tuser !== e.pv || m_axis_tdata[19:0] !== e.addr ||
            m_axis_tdata[35:20] !== e.color || m_axis_tdata[37:36] !== e.status ||
            m_axis_tdata[39:38] !== 2'b00 || m_axis_tlast !== e.done)
          note_mismatch($sformatf(
            "exp valid=%b addr=%h color=%h status=%0d done=%b, got valid=%b addr=%h color=%h status=%0d done=%b pad=%b",
            e.pv, e.addr, e.color, e.status, e.done, m_axis_tuser, m_axis_tdata[19:0],
            m_axis_tdata[35:20], m_axis_tdata[37:36], m_axis_tlast, m_axis_tdata[39:38]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      long_hold--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration helpers
  // --------------------------------------------------------------------------

  // Offer one payload byte, hold it until taken, then predict its result.
  task automatic send_byte(input bit [7:0] b, input bit last);
    fb_write_t r;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (decode_byte(b, last, r)) pending_writes.push_back(r);
  endtask

  // Send frame_q; tvalid stays up so the next frame can follow at once.
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i].b, frame_q[i].l);
    frames_sent++;
  endtask

  // Drop the input valid, drain all predicted writes and let the parser settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_read_check(input int idx, input int unsigned exp_val);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= 4'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== exp_val)
      note_mismatch($sformatf("register %0d read %h, exp %h", idx, prdata, exp_val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register while the block is idle and read it back.
  task automatic set_reg(input int idx, input int unsigned v);
    int unsigned m;
    wait_idle();
    m = (idx <= REG_HEIGHT) ? (v & 32'h7FF) : (v & 32'h1);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_w = m;
      REG_HEIGHT: cfg_h = m;
      REG_INDEX:  cfg_idx = m[0];
      default:    cfg_tiled = m[0];
    endcase
    @(posedge clk);
    apb_read_check(idx, m);
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, h, input bit ix, tl);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    set_reg(REG_INDEX, ix);
    set_reg(REG_TILED, tl);
  endtask

  function automatic void push_byte(input int unsigned b);
    frame_q.push_back('{b: b[7:0], l: 1'b0});
  endfunction

  function automatic void push16(input int unsigned v);
    push_byte(v & 8'hFF);
    push_byte((v >> 8) & 8'hFF);
  endfunction

  // Build one payload for the current registers into frame_q.
  function automatic void build_frame(frame_kind_e kind);
    int unsigned nt, np, npix, tpr, tpc, cut, bad_at;
    frame_q.delete();
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 12)) push_byte($urandom_range(0, 255));
    end else begin
      nt = 0;
      np = 0;
      tpr = (eff_w() + 7) >> 3;
      tpc = (eff_h() + 7) >> 3;
      if (cfg_tiled) begin
        nt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
        push16(nt);
        bad_at = (kind == FK_CORRUPT) ? $urandom_range(0, nt) : nt;
        for (int i = 0; i < nt; i++) begin
          if (i == bad_at || tpr * tpc == 0) push16($urandom_range(0, 65535));
          else push16($urandom_range(0, tpr * tpc - 1));
        end
      end
      if (cfg_idx) begin
        if (kind == FK_CORRUPT && $urandom_range(0, 2) == 0) np = 0;
        else if ($urandom_range(0, 5) == 0) np = $urandom_range(257, 262);
        else np = $urandom_range(1, 8);
        push16(np);
        repeat (np) push16($urandom_range(0, 65535));
      end
      npix = cfg_tiled ? nt * 64 : eff_w() * eff_h();
      for (int i = 0; i < npix; i++) begin
        if (cfg_idx) begin
          if (kind == FK_CORRUPT && $urandom_range(0, 15) == 0)
            push_byte($urandom_range(0, 255));
          else
            push_byte($urandom_range(0, ((np > 256) ? 256 : np) - 1));
        end else begin
          push16($urandom_range(0, 65535));
        end
      end
      if (frame_q.size() == 0) push_byte($urandom_range(0, 255));
      if (kind == FK_EARLY && frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      if (kind == FK_TRAIL) repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255));
    end
    frame_q[frame_q.size() - 1].l = 1'b1;
  endfunction

  function automatic int unsigned pick_size(input bit tl);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return tl ? 1024 : 8;
      3: return tl ? 2047 : 7;
      default: return $urandom_range(2, tl ? 40 : 6);
    endcase
  endfunction

  function automatic frame_kind_e pick_kind();
    case ($urandom_range(0, 9))
      0, 1: return FK_EARLY;
      2: return FK_TRAIL;
      3: return FK_CORRUPT;
      4: return FK_NOISE;
      default: return FK_GOOD;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    apb_read_check(REG_WIDTH, 256);
    @(posedge clk);
    apb_read_check(REG_HEIGHT, 192);
    @(posedge clk);
    apb_read_check(REG_INDEX, 0);
    @(posedge clk);
    apb_read_check(REG_TILED, 0);
    @(posedge clk);
    // a short frame under the reset size ends early
    frame_q.delete();
    push16(16'hA55A);
    frame_q[1].l = 1'b1;
    send_frame();
  endtask

  task automatic test_directed_frames();
    // raw 2x1: all-zero and all-one colors
    set_frame(2, 1, 0, 0);
    frame_q.delete();
    push16(16'h0000);
    push16(16'hFFFF);
    frame_q[3].l = 1'b1;
    send_frame();
    // zero width: nothing due, first byte closes the frame
    set_reg(REG_WIDTH, 0);
    frame_q.delete();
    push_byte(8'hFF);
    frame_q[0].l = 1'b1;
    send_frame();
    // indexed: zero palette count is corrupt, rest is drained
    set_frame(1, 1, 1, 0);
    frame_q.delete();
    push16(0);
    push_byte(8'h00);
    frame_q[2].l = 1'b1;
    send_frame();
    // indexed: palette index not below the count
    frame_q.delete();
    push16(1);
    push16(16'h1234);
    push_byte(8'h01);
    frame_q[4].l = 1'b1;
    send_frame();
    // tiled, oversize frame saturates; last tile index, then early end
    set_frame(2047, 2047, 0, 1);
    frame_q.delete();
    push16(1);
    push16(16'h3FFF);
    push16(16'h55AA);
    push16(16'h2211);
    frame_q[7].l = 1'b1;
    send_frame();
    // tile count above the store
    frame_q.delete();
    push16(N_TILES + 1);
    push_byte(8'h00);
    frame_q[2].l = 1'b1;
    send_frame();
  endtask

  task automatic test_output_backpressure();
    // hold the receiver off while a raw 8x8 frame keeps coming
    set_frame(8, 8, 0, 0);
    long_hold = 400;
    build_frame(FK_GOOD);
    send_frame();
  endtask

  task automatic test_random_frames(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        cfg_tiled = $urandom_range(0, 1);
        set_frame(pick_size(cfg_tiled), pick_size(cfg_tiled), $urandom_range(0, 1),
                  cfg_tiled);
      end
      build_frame(pick_kind());
      send_frame();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_frames();
    test_output_backpressure();
    test_random_frames(TARGET_ITEMS - 200 - items_sent);
    // final stretch runs with no idling on either side
    wait_idle();
    idle_en = 1'b0;
    test_random_frames(200);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (pending_writes.size() != 0) note_mismatch("predicted writes never arrived");
    $display("covered %0d payload bytes in %0d frames: %0d output transactions, %0d closes",
             items_sent, frames_sent, writes_seen, closes_seen);
    $display("raw, indexed and tiled modes with early ends, corrupt data and overflow");
    if (mismatches == 0) begin
      $display("tiled_palette_frame_decoder_top_test OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tiled_palette_frame_decoder_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpfd_pkg.sv
sv/tpfd_ram.sv
sv/tpfd_div.sv
sv/tiled_palette_frame_decoder_top.sv
tb/tiled_palette_frame_decoder_top_test.sv
